>>> rtl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants of the pitch complementary filter
// Fixed-point formats, register indexes, queue item layout and the CORDIC
// arctangent table in degrees Q24.
// ----------------------------------------------------------------------------
package pcf_pkg;

    // Angle formats
    localparam int PCF_ANGLE_FRAC   = 7;               // output angles in 2^-7 degree
    localparam int PCF_TABLE_FRAC   = 24;              // CORDIC angle table in Q24 degree
    localparam int PCF_ACC_EXTRA    = 16;              // extra fraction bits of the state
    localparam int PCF_INC_SHIFT    = 12 - PCF_ANGLE_FRAC;
    localparam int PCF_Z_SHIFT      = PCF_TABLE_FRAC - PCF_ANGLE_FRAC;

    // Default CORDIC length and table size
    localparam int PCF_CORDIC_STEPS = 16;
    localparam int PCF_TBL_DEPTH    = 24;
    localparam int PCF_TBL_IDX_W    = 5;

    // Square root: 32-bit radicand scaled by 2^24 gives a 28-bit root
    localparam int PCF_SQ_W         = 32;
    localparam int PCF_ROOT_W       = 28;
    localparam int PCF_SQRT_ITERS   = 28;
    localparam int PCF_SQRT_CNT_W   = 5;

    // Queue between front and back, power of two
    localparam int PCF_QUEUE_DEPTH  = 2;

    // Configuration port
    localparam int PCF_CFG_IDX_W    = 2;
    localparam int PCF_CFG_DATA_W   = 24;
    localparam logic [PCF_CFG_IDX_W-1:0] PCF_REG_BLEND  = 2'd0;
    localparam logic [PCF_CFG_IDX_W-1:0] PCF_REG_PERIOD = 2'd1;
    localparam logic [15:0] PCF_BLEND_RESET  = 16'd58982;
    localparam logic [23:0] PCF_PERIOD_RESET = 24'd16777;

    // Item class decided by the front
    typedef enum logic {
        PCF_KIND_TILT,      // regular case, run root and CORDIC
        PCF_KIND_AXIS       // y and z both zero, pitch is fixed
    } t_pcf_kind;

    // Item held in the queue
    typedef struct packed {
        logic signed [15:0]   acc_x;
        logic signed [15:0]   gyro_rate;
        logic [PCF_SQ_W-1:0]  sq;
        t_pcf_kind            kind;
    } t_pcf_item;

    // Configuration registers
    typedef struct packed {
        logic [15:0] blend_weight;
        logic [23:0] period_q24;
    } t_pcf_cfg;

    // atan(2^-i) in degrees Q24
    function automatic logic signed [31:0] atan_q24(input logic [PCF_TBL_IDX_W-1:0] idx);
        unique case (idx)
            5'd0:    return 32'sd754974720;
            5'd1:    return 32'sd445687602;
            5'd2:    return 32'sd235489088;
            5'd3:    return 32'sd119537938;
            5'd4:    return 32'sd60000934;
            5'd5:    return 32'sd30029717;
            5'd6:    return 32'sd15018523;
            5'd7:    return 32'sd7509720;
            5'd8:    return 32'sd3754917;
            5'd9:    return 32'sd1877466;
            5'd10:   return 32'sd938734;
            5'd11:   return 32'sd469367;
            5'd12:   return 32'sd234684;
            5'd13:   return 32'sd117342;
            5'd14:   return 32'sd58671;
            5'd15:   return 32'sd29335;
            5'd16:   return 32'sd14668;
            5'd17:   return 32'sd7334;
            5'd18:   return 32'sd3667;
            5'd19:   return 32'sd1833;
            5'd20:   return 32'sd917;
            5'd21:   return 32'sd458;
            5'd22:   return 32'sd229;
            5'd23:   return 32'sd115;
            default: return 32'sd0;
        endcase
    endfunction

endpackage

>>> rtl/pcf_front.sv
// ----------------------------------------------------------------------------
// pcf_front: input stage of the pitch filter
// Accepts one sample, forms ay^2 + az^2 and classifies the sample, then
// hands it to the queue.
// ----------------------------------------------------------------------------
module pcf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_acc_x,
    input  logic signed [15:0]   i_acc_y,
    input  logic signed [15:0]   i_acc_z,
    input  logic signed [15:0]   i_gyro_rate,
    output logic                 o_push,
    input  logic                 i_push_ready,
    output pcf_pkg::t_pcf_item   o_item
);

    logic                          r_valid;
    pcf_pkg::t_pcf_item            r_item;
    logic signed [31:0]            sq_y;
    logic signed [31:0]            sq_z;
    logic [pcf_pkg::PCF_SQ_W-1:0]  sq;
    logic                          accept;

    // Sum of squares of the two other axes
    assign sq_y = i_acc_y * i_acc_y;
    assign sq_z = i_acc_z * i_acc_z;
    assign sq   = pcf_pkg::PCF_SQ_W'($unsigned(sq_y)) + pcf_pkg::PCF_SQ_W'($unsigned(sq_z));

    // Take a new request whenever the holding register empties this cycle
    assign o_ready = !r_valid || i_push_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid          <= 1'b1;
                r_item.acc_x     <= i_acc_x;
                r_item.gyro_rate <= i_gyro_rate;
                r_item.sq        <= sq;
                r_item.kind      <= (sq == '0) ? pcf_pkg::PCF_KIND_AXIS
                                               : pcf_pkg::PCF_KIND_TILT;
            end else if (i_push_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/pcf_queue.sv
// ----------------------------------------------------------------------------
// pcf_queue: short queue between front and back
// Small register queue; depth is a power of two so the pointers wrap freely.
// ----------------------------------------------------------------------------
module pcf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_push_ready,
    input  pcf_pkg::t_pcf_item  i_item,
    output logic                o_valid,
    input  logic                i_pop,
    output pcf_pkg::t_pcf_item  o_item
);

    localparam int DEPTH = pcf_pkg::PCF_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    pcf_pkg::t_pcf_item  r_mem [DEPTH];
    logic [PW-1:0]       r_wptr;
    logic [PW-1:0]       r_rptr;
    logic [CW-1:0]       r_count;
    logic                do_push;
    logic                do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_item       = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/pcf_back.sv
// ----------------------------------------------------------------------------
// pcf_back: execution sequencer of the pitch filter
// Bit-serial square root, iterative CORDIC arctangent, gyro integration and
// blend in a few multiply steps, then a result register toward the output.
// ----------------------------------------------------------------------------
module pcf_back #(
    parameter int CORDIC_STEPS = pcf_pkg::PCF_CORDIC_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcf_pkg::t_pcf_cfg    i_cfg,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  pcf_pkg::t_pcf_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_fused_pitch,
    output logic signed [14:0]   o_accel_pitch
);

    localparam int CW   = $clog2(CORDIC_STEPS);
    localparam int IW   = pcf_pkg::PCF_TBL_IDX_W;
    localparam int RW   = pcf_pkg::PCF_ROOT_W;
    localparam int SW   = pcf_pkg::PCF_SQRT_CNT_W;
    localparam int ZSH  = pcf_pkg::PCF_Z_SHIFT;
    localparam int ISH  = pcf_pkg::PCF_INC_SHIFT;
    localparam int XSH  = pcf_pkg::PCF_ACC_EXTRA;
    localparam logic signed [14:0] NINETY     = 15'sd11520;
    localparam logic signed [32:0] NINETY33   = 33'sd11520;
    localparam logic signed [32:0] HALF180    = 33'sd23040;
    localparam logic signed [40:0] ANGLE_LIM  = 41'sd1509949440;
    localparam logic signed [32:0] Z_HALF     = 33'sd1 <<< (ZSH - 1);
    localparam logic signed [40:0] INC_HALF   = 41'sd1 <<< (ISH - 1);
    localparam logic signed [32:0] OUT_HALF   = 33'sd1 <<< (XSH - 1);
    localparam logic signed [55:0] MIX_HALF   = 56'sd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_ACCEL,
        ST_GYRO,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_FUSE,
        ST_OUT
    } t_state;

    t_state                 r_state;
    logic                   r_seeded;
    logic                   r_out_valid;
    logic signed [15:0]     r_out_fused;
    logic signed [14:0]     r_out_accel;

    logic signed [15:0]     r_ax;
    logic signed [15:0]     r_rate;
    logic [31:0]            r_rad;
    logic [31:0]            r_rem;
    logic [RW-1:0]          r_root;
    logic [SW-1:0]          r_scnt;
    logic signed [31:0]     r_x;
    logic signed [31:0]     r_y;
    logic signed [31:0]     r_z;
    logic [CW-1:0]          r_ccnt;
    logic signed [14:0]     r_acc;
    logic signed [31:0]     r_angle;
    logic signed [40:0]     r_prod;
    logic signed [37:0]     r_diff;
    logic [35:0]            r_plo;
    logic signed [34:0]     r_phi;
    logic signed [39:0]     r_mix;

    // Square root step
    logic [31:0]            rem_sh;
    logic [31:0]            trial;
    logic                   root_ge;
    logic [31:0]            n_rem;
    logic [RW-1:0]          n_root;

    // CORDIC step
    logic [IW-1:0]          sh;
    logic signed [31:0]     dx;
    logic signed [31:0]     dy;
    logic signed [31:0]     ang;
    logic signed [31:0]     n_x;
    logic signed [31:0]     n_y;
    logic signed [31:0]     n_z;

    // Angle rounding and blend
    logic signed [32:0]     z_round;
    logic signed [32:0]     z_neg;
    logic signed [14:0]     n_acc;
    logic signed [14:0]     axis_acc;
    logic signed [30:0]     acc_ext;
    logic signed [40:0]     inc_full;
    logic signed [37:0]     n_diff;
    logic signed [55:0]     mix_full;
    logic signed [40:0]     fuse_sum;
    logic signed [31:0]     n_angle;
    logic signed [32:0]     out_round;
    logic signed [15:0]     n_fused;

    assign o_pop         = (r_state == ST_IDLE) && i_valid;
    assign o_valid       = r_out_valid;
    assign o_fused_pitch = r_out_fused;
    assign o_accel_pitch = r_out_accel;

    // Restoring square root, one root bit per cycle
    always_comb begin
        rem_sh  = {r_rem[29:0], r_rad[31:30]};
        trial   = {2'b00, r_root, 2'b01};
        root_ge = (rem_sh >= trial);
        n_rem   = root_ge ? (rem_sh - trial) : rem_sh;
        n_root  = {r_root[RW-2:0], root_ge};
    end

    // CORDIC vectoring step: drive y toward zero
    always_comb begin
        sh  = IW'(r_ccnt);
        dx  = r_y >>> sh;
        dy  = r_x >>> sh;
        ang = pcf_pkg::atan_q24(sh);
        if (r_y > 32'sd0) begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + ang;
        end else begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - ang;
        end
    end

    // Accelerometer pitch: round, negate and clamp to ninety degrees
    always_comb begin
        z_round = (33'(r_z) + Z_HALF) >>> ZSH;
        z_neg   = -z_round;
        if (z_neg > NINETY33) begin
            n_acc = NINETY;
        end else if (z_neg < -NINETY33) begin
            n_acc = -NINETY;
        end else begin
            n_acc = 15'(z_neg);
        end
        if (i_item.acc_x > 16'sd0) begin
            axis_acc = -NINETY;
        end else if (i_item.acc_x < 16'sd0) begin
            axis_acc = NINETY;
        end else begin
            axis_acc = 15'sd0;
        end
    end

    // Gyro step and blend arithmetic
    always_comb begin
        acc_ext  = $signed({r_acc, 16'h0000});
        inc_full = (r_prod + INC_HALF) >>> ISH;
        n_diff   = 38'(r_angle) + 38'(inc_full) - 38'(acc_ext);
        mix_full = (56'(r_phi) <<< 20) + $signed(56'(r_plo)) + MIX_HALF;
        fuse_sum = 41'(acc_ext) + 41'(r_mix);
        if (!r_seeded) begin
            n_angle = 32'(acc_ext);
        end else if (fuse_sum > ANGLE_LIM) begin
            n_angle = 32'(ANGLE_LIM);
        end else if (fuse_sum < -ANGLE_LIM) begin
            n_angle = 32'(-ANGLE_LIM);
        end else begin
            n_angle = 32'(fuse_sum);
        end
        out_round = (33'(r_angle) + OUT_HALF) >>> XSH;
        if (out_round > HALF180) begin
            n_fused = 16'(HALF180);
        end else if (out_round < -HALF180) begin
            n_fused = 16'(-HALF180);
        end else begin
            n_fused = 16'(out_round);
        end
    end

    // Sequencer, datapath registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop a taken result unless a new one is loaded this cycle
            if (r_out_valid && i_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_ax   <= i_item.acc_x;
                        r_rate <= i_item.gyro_rate;
                        r_rad  <= i_item.sq;
                        r_rem  <= '0;
                        r_root <= '0;
                        r_scnt <= '0;
                        if (i_item.kind == pcf_pkg::PCF_KIND_AXIS) begin
                            r_acc   <= axis_acc;
                            r_state <= ST_GYRO;
                        end else begin
                            r_state <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    r_rad  <= {r_rad[29:0], 2'b00};
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_scnt <= r_scnt + SW'(1);
                    if (r_scnt == SW'(pcf_pkg::PCF_SQRT_ITERS - 1)) begin
                        r_x     <= 32'($unsigned(n_root));
                        r_y     <= $signed({{4{r_ax[15]}}, r_ax, 12'h000});
                        r_z     <= '0;
                        r_ccnt  <= '0;
                        r_state <= ST_CORDIC;
                    end
                end
                ST_CORDIC: begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_z    <= n_z;
                    r_ccnt <= r_ccnt + CW'(1);
                    if (r_ccnt == CW'(CORDIC_STEPS - 1)) begin
                        r_state <= ST_ACCEL;
                    end
                end
                ST_ACCEL: begin
                    r_acc   <= n_acc;
                    r_state <= ST_GYRO;
                end
                ST_GYRO: begin
                    r_prod  <= r_rate * $signed({1'b0, i_cfg.period_q24});
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_diff  <= n_diff;
                    r_state <= ST_MUL_LO;
                end
                ST_MUL_LO: begin
                    r_plo   <= i_cfg.blend_weight * r_diff[19:0];
                    r_state <= ST_MUL_HI;
                end
                ST_MUL_HI: begin
                    r_phi   <= $signed({1'b0, i_cfg.blend_weight}) * $signed(r_diff[37:20]);
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_mix   <= 40'(mix_full >>> 16);
                    r_state <= ST_FUSE;
                end
                ST_FUSE: begin
                    r_angle  <= n_angle;
                    r_seeded <= 1'b1;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    // Hold until the result register is free
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_fused <= n_fused;
                        r_out_accel <= r_acc;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/pitch_complementary_filter.sv
// ----------------------------------------------------------------------------
// pitch_complementary_filter: IMU pitch complementary filter, top level
// The path from accepted sample to result valid runs mostly through the
//   bit-serial square root and the CORDIC loop; y and z both 0 skip both.
// The back end finishes one sample before it pops the next one from the queue.
// A two-entry queue lets samples be taken while the back end is busy.
// Reset: synchronous, active low; clears the seed flag, loads register defaults.
// ----------------------------------------------------------------------------
module pitch_complementary_filter #(
    parameter int CORDIC_STEPS = pcf_pkg::PCF_CORDIC_STEPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input samples
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [15:0] acc_x, [31:16] acc_y, [47:32] acc_z, [63:48] gyro_rate
    input  logic [63:0]                          i_s_axis_tdata,
    // Results
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [15:0] fused_pitch, [30:16] accel_pitch, [31] zero
    output logic [31:0]                          o_m_axis_tdata,
    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcf_pkg::PCF_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pcf_pkg::PCF_CFG_DATA_W-1:0]   i_cfg_data
);

    pcf_pkg::t_pcf_cfg   r_cfg;
    pcf_pkg::t_pcf_item  front_item;
    pcf_pkg::t_pcf_item  queue_item;
    logic                front_push;
    logic                queue_push_ready;
    logic                queue_valid;
    logic                back_pop;
    logic signed [15:0]  fused_pitch;
    logic signed [14:0]  accel_pitch;

    // Configuration registers; writes beyond the list are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_weight <= pcf_pkg::PCF_BLEND_RESET;
            r_cfg.period_q24   <= pcf_pkg::PCF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcf_pkg::PCF_REG_BLEND:  r_cfg.blend_weight <= i_cfg_data[15:0];
                pcf_pkg::PCF_REG_PERIOD: r_cfg.period_q24   <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // Accept and classify
    pcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_acc_x      ($signed(i_s_axis_tdata[15:0])),
        .i_acc_y      ($signed(i_s_axis_tdata[31:16])),
        .i_acc_z      ($signed(i_s_axis_tdata[47:32])),
        .i_gyro_rate  ($signed(i_s_axis_tdata[63:48])),
        .o_push       (front_push),
        .i_push_ready (queue_push_ready),
        .o_item       (front_item)
    );

    // Decouple front and back
    pcf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .o_push_ready (queue_push_ready),
        .i_item       (front_item),
        .o_valid      (queue_valid),
        .i_pop        (back_pop),
        .o_item       (queue_item)
    );

    // Compute pitch and blend
    pcf_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (queue_valid),
        .o_pop         (back_pop),
        .i_item        (queue_item),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_fused_pitch (fused_pitch),
        .o_accel_pitch (accel_pitch)
    );

    assign o_m_axis_tdata = {1'b0, accel_pitch, fused_pitch};

endmodule
